// ===== rtl/core/uart_pkg.sv =====
// Shared types and constants for the 8N1 UART transceiver.
// No dependencies; used by uart_tx, uart_rx and uart_8n1_transceiver.
package uart_pkg;

	localparam logic [15:0] BIT_PERIOD_RST = 16'd104;

	typedef struct packed {
		logic       rx_line;
		logic       tx_request;
		logic [7:0] tx_byte;
	} uart_in_t;

	typedef struct packed {
		logic       tx_line;
		logic       tx_busy;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} uart_out_t;

	typedef struct packed {
		logic line;
		logic busy;
	} tx_res_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} rx_res_t;

	typedef enum logic [3:0] {
		TX_IDLE  = 4'b0001,
		TX_START = 4'b0010,
		TX_DATA  = 4'b0100,
		TX_STOP  = 4'b1000
	} tx_phase_t;

	typedef enum logic [3:0] {
		RX_IDLE  = 4'b0001,
		RX_FIRST = 4'b0010,
		RX_BITS  = 4'b0100,
		RX_TAIL  = 4'b1000
	} rx_phase_t;

endpackage

// ===== rtl/core/uart_8n1_transceiver.sv =====
// Top level of the 8N1 UART transceiver: bit period register, tick handshake, result register.
// Depends on uart_pkg, uart_tx and uart_rx.
//
//  channel   dir  handshake                   payload
//  in        in   in_valid / in_stall         uart_pkg::uart_in_t  (one tick)
//  out       out  out_valid / out_stall       uart_pkg::uart_out_t (one result per tick)
//  cfg       in   cfg_we                      cfg_data = bit_period
//
// One beat per cycle: a tick is accepted whenever the result register is empty or being
// taken, and its result appears in the result register on the next cycle.
// The result passes through the single result register after the tx and rx step logic.
// After reset both sides are idle, bit_period is 104 and the first result's rx_byte reads 0.
// A stall on out holds the result and stalls in; frame timing counts ticks, not cycles.
module uart_8n1_transceiver #(
	parameter int DATA_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  uart_pkg::uart_in_t    in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output uart_pkg::uart_out_t   out_data,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_data
);

	logic [15:0]          bit_period_q;
	logic                 step;
	logic                 out_valid_q;
	uart_pkg::uart_out_t  out_q;
	uart_pkg::tx_res_t    tx_res;
	uart_pkg::rx_res_t    rx_res;

	assign in_stall  = out_valid_q && out_stall;
	assign step      = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bit_period_q <= uart_pkg::BIT_PERIOD_RST;
		else if (cfg_we)
			bit_period_q <= cfg_data;
	end

	uart_tx #(.DATA_BITS(DATA_BITS)) u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.req        (in_data.tx_request),
		.tx_byte    (in_data.tx_byte),
		.bit_period (bit_period_q),
		.res        (tx_res)
	);

	uart_rx #(.DATA_BITS(DATA_BITS)) u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_line    (in_data.rx_line),
		.bit_period (bit_period_q),
		.res        (rx_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.tx_line  <= tx_res.line;
			out_q.tx_busy  <= tx_res.busy;
			out_q.rx_valid <= rx_res.valid;
			out_q.rx_byte  <= rx_res.rx_byte;
		end
	end

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("accepted tick beat produced no result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result register");

	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.tx_busy) |-> out_data.tx_line)
		else $error("tx line low while transmitter idle");

endmodule

// ===== rtl/core/uart_tx.sv =====
// Transmit framer: start bit, data bits LSB first, stop bit, one tick per step.
// Depends on uart_pkg.
module uart_tx #(
	parameter int DATA_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               req,
	input  logic [7:0]         tx_byte,
	input  logic [15:0]        bit_period,
	output uart_pkg::tx_res_t  res
);

	localparam int CW = $clog2(DATA_BITS + 1);

	uart_pkg::tx_phase_t    phase_q, phase_d;
	logic [CW-1:0]          bit_q, bit_d;
	logic [DATA_BITS-1:0]   shift_q, shift_d;
	logic [15:0]            tick_q, tick_d;
	logic [DATA_BITS+7:0]   byte_ext;

	assign byte_ext = {{DATA_BITS{1'b0}}, tx_byte};

	always_comb begin
		logic [16:0] tick_nx;
		uart_pkg::tx_phase_t cur;
		logic [CW-1:0] bit_nx;
		cur      = phase_q;
		shift_d  = shift_q;
		bit_d    = bit_q;
		tick_d   = tick_q;
		res.line = 1'b1;
		res.busy = 1'b0;
		// an accepted request drives the start bit on this same tick
		if (phase_q == uart_pkg::TX_IDLE && req) begin
			cur     = uart_pkg::TX_START;
			shift_d = byte_ext[DATA_BITS-1:0];
			bit_d   = '0;
			tick_d  = '0;
		end
		phase_d = cur;
		tick_nx = {1'b0, tick_d} + 17'd1;
		bit_nx  = bit_d + CW'(1);
		if (cur != uart_pkg::TX_IDLE) begin
			res.busy = 1'b1;
			case (cur)
				uart_pkg::TX_START: res.line = 1'b0;
				uart_pkg::TX_DATA:  res.line = shift_d[0];
				default:            res.line = 1'b1;
			endcase
			if (tick_nx >= {1'b0, bit_period}) begin
				tick_d = '0;
				case (cur)
					uart_pkg::TX_START: begin
						phase_d = uart_pkg::TX_DATA;
						bit_d   = '0;
					end
					uart_pkg::TX_DATA: begin
						shift_d = shift_d >> 1;
						bit_d   = bit_nx;
						if (bit_nx >= CW'(DATA_BITS))
							phase_d = uart_pkg::TX_STOP;
					end
					default: begin
						phase_d = uart_pkg::TX_IDLE;
						bit_d   = '0;
					end
				endcase
			end else begin
				tick_d = tick_nx[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uart_pkg::TX_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			tick_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			tick_q  <= tick_d;
		end
	end

endmodule

// ===== rtl/core/uart_rx.sv =====
// Receive sampler: start detect, mid-bit sampling, byte hand-off after the tail wait.
// Depends on uart_pkg.
module uart_rx #(
	parameter int DATA_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               rx_line,
	input  logic [15:0]        bit_period,
	output uart_pkg::rx_res_t  res
);

	localparam int CW = $clog2(DATA_BITS + 1);

	uart_pkg::rx_phase_t    phase_q, phase_d;
	logic [CW-1:0]          bit_q, bit_d;
	logic [DATA_BITS-1:0]   shift_q, shift_d;
	logic [16:0]            tick_q, tick_d;
	logic [7:0]             last_q;
	logic [DATA_BITS+7:0]   shift_ext;

	assign shift_ext = {8'b0, shift_q};

	always_comb begin
		logic [16:0] target;
		logic [17:0] tick_nx;
		logic [CW-1:0] bit_nx;
		phase_d     = phase_q;
		bit_d       = bit_q;
		shift_d     = shift_q;
		tick_d      = tick_q;
		res.valid   = 1'b0;
		res.rx_byte = last_q;
		// 1.5 periods for the first sample and the tail
		target  = (phase_q == uart_pkg::RX_BITS) ? {1'b0, bit_period}
			: ({1'b0, bit_period} + {2'b0, bit_period[15:1]});
		tick_nx = {1'b0, tick_q} + 18'd1;
		bit_nx  = bit_q + CW'(1);
		if (phase_q == uart_pkg::RX_IDLE) begin
			if (!rx_line) begin
				phase_d = uart_pkg::RX_FIRST;
				tick_d  = '0;
				bit_d   = '0;
				shift_d = '0;
			end
		end else if (tick_nx >= {1'b0, target}) begin
			tick_d = '0;
			if (phase_q == uart_pkg::RX_TAIL) begin
				res.valid   = 1'b1;
				res.rx_byte = shift_ext[7:0];
				phase_d     = uart_pkg::RX_IDLE;
				bit_d       = '0;
			end else begin
				shift_d = shift_q | (DATA_BITS'(rx_line) << bit_q);
				bit_d   = bit_nx;
				phase_d = (bit_nx >= CW'(DATA_BITS)) ? uart_pkg::RX_TAIL
					: uart_pkg::RX_BITS;
			end
		end else begin
			tick_d = tick_nx[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uart_pkg::RX_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			tick_q  <= '0;
			last_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			tick_q  <= tick_d;
			last_q  <= res.rx_byte;
		end
	end

endmodule

// ===== tb/sv/uart_line_checker.sv =====
`timescale 1ns / 100ps
// Checker for uart_8n1_transceiver: tracks tick beats, result beats and bit period writes,
// predicts every result and compares it field by field. Depends on uart_pkg.
module uart_line_checker #(
	parameter int DATA_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  uart_pkg::uart_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  uart_pkg::uart_out_t out_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	output int                  mismatches,
	output int                  pins_pending,
	output int                  ticks_checked,
	output int                  frames_started,
	output int                  bytes_received
);

	logic [15:0]         period;
	uart_pkg::tx_phase_t tx_ph;
	int unsigned         tx_bits;
	int unsigned         tx_ticks;
	logic [15:0]         tx_sr;
	uart_pkg::rx_phase_t rx_ph;
	int unsigned         rx_bits;
	int unsigned         rx_ticks;
	logic [31:0]         rx_sr;
	logic [7:0]          rx_held;
	uart_pkg::uart_out_t want;
	uart_pkg::uart_out_t expected_pins[$];

	// Advances the transmitter and receiver by one tick and returns the pin levels.
	function automatic uart_pkg::uart_out_t next_pin_levels(input uart_pkg::uart_in_t t);
		uart_pkg::uart_out_t r;
		int unsigned         wait_len;
		r = '0;
		r.tx_line = 1'b1;
		if (tx_ph == uart_pkg::TX_IDLE && t.tx_request) begin
			tx_ph = uart_pkg::TX_START;
			tx_sr = {8'h00, t.tx_byte};
			tx_bits = 0;
			tx_ticks = 0;
			frames_started++;
		end
		if (tx_ph != uart_pkg::TX_IDLE) begin
			r.tx_busy = 1'b1;
			case (tx_ph)
				uart_pkg::TX_START: r.tx_line = 1'b0;
				uart_pkg::TX_DATA:  r.tx_line = tx_sr[0];
				default:            r.tx_line = 1'b1;
			endcase
			tx_ticks++;
			// a counter already past a shortened period ends the bit here
			if (tx_ticks >= period) begin
				tx_ticks = 0;
				case (tx_ph)
					uart_pkg::TX_START: begin
						tx_ph = uart_pkg::TX_DATA;
						tx_bits = 0;
					end
					uart_pkg::TX_DATA: begin
						tx_sr = tx_sr >> 1;
						tx_bits++;
						if (tx_bits >= DATA_BITS)
							tx_ph = uart_pkg::TX_STOP;
					end
					default: begin
						tx_ph = uart_pkg::TX_IDLE;
						tx_bits = 0;
					end
				endcase
			end
		end

		if (rx_ph == uart_pkg::RX_IDLE) begin
			if (!t.rx_line) begin
				rx_ph = uart_pkg::RX_FIRST;
				rx_ticks = 0;
				rx_bits = 0;
				rx_sr = '0;
			end
		end else begin
			// first sample and tail wait 1.5 periods, data bits one period
			wait_len = (rx_ph == uart_pkg::RX_BITS) ? period : period + (period >> 1);
			rx_ticks++;
			if (rx_ticks >= wait_len) begin
				rx_ticks = 0;
				if (rx_ph == uart_pkg::RX_TAIL) begin
					rx_held = rx_sr[7:0];
					r.rx_valid = 1'b1;
					rx_ph = uart_pkg::RX_IDLE;
					rx_bits = 0;
					bytes_received++;
				end else begin
					if (rx_bits < 31)
						rx_sr[rx_bits] = t.rx_line;
					rx_bits++;
					rx_ph = (rx_bits >= DATA_BITS) ? uart_pkg::RX_TAIL : uart_pkg::RX_BITS;
				end
			end
		end
		r.rx_byte = rx_held;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] act_val);
		if (act_val !== exp_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period = uart_pkg::BIT_PERIOD_RST;
			tx_ph = uart_pkg::TX_IDLE;
			tx_bits = 0;
			tx_ticks = 0;
			tx_sr = '0;
			rx_ph = uart_pkg::RX_IDLE;
			rx_bits = 0;
			rx_ticks = 0;
			rx_sr = '0;
			rx_held = '0;
			expected_pins.delete();
			mismatches = 0;
			pins_pending = 0;
			ticks_checked = 0;
			frames_started = 0;
			bytes_received = 0;
		end else begin
			if (cfg_we)
				period = cfg_data;
			// result beat first: it always belongs to an earlier tick beat
			if (out_valid && !out_stall) begin
				if (expected_pins.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected, expected none, actual %h",
						$time, out_data);
				end else begin
					want = expected_pins.pop_front();
					check_field("tx_line", 8'(want.tx_line), 8'(out_data.tx_line));
					check_field("tx_busy", 8'(want.tx_busy), 8'(out_data.tx_busy));
					check_field("rx_valid", 8'(want.rx_valid), 8'(out_data.rx_valid));
					check_field("rx_byte", want.rx_byte, out_data.rx_byte);
					ticks_checked++;
				end
			end
			if (in_valid && !in_stall)
				expected_pins.push_back(next_pin_levels(in_data));
			pins_pending = expected_pins.size();
		end
	end

endmodule

// ===== tb/sv/uart_8n1_transceiver_test.sv =====
`timescale 1ns / 100ps
// Testbench top for uart_8n1_transceiver: clock, reset, serial tick stimulus with gaps and
// stalls, watchdog and verdict. Depends on uart_pkg and uart_line_checker.
module uart_8n1_transceiver_test;

	localparam int HOLD_CYCLES = 160;
	localparam int IDLE_LIMIT = 2000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	uart_pkg::uart_in_t  in_data;
	logic                out_valid;
	logic                out_stall;
	uart_pkg::uart_out_t out_data;
	logic                cfg_we;
	logic [15:0]         cfg_data;

	int mismatches, pins_pending, ticks_checked, frames_started, bytes_received;
	int gap_pct, stall_pct, req_pct;
	int idle_cycles = 0;
	int ticks_sent = 0;
	int settings_used = 0;
	int bit_ticks;
	bit hold_armed;
	bit hold_done;

	uart_8n1_transceiver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	uart_line_checker line_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pins_pending   (pins_pending),
		.ticks_checked  (ticks_checked),
		.frames_started (frames_started),
		.bytes_received (bytes_received)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(12, 40);
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Receiver side: random stalls, plus one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
				hold_done = 1'b1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall = 1'b1;
				repeat (gap_len()) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// One tick beat; called and returns at a falling edge.
	task automatic send_tick(input logic rx, input logic req, input logic [7:0] data);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid = 1'b0;
			repeat (gap_len()) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = '{rx_line: rx, tx_request: req, tx_byte: data};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic line_tick(input logic rx);
		send_tick(rx, $urandom_range(0, 99) < req_pct, rand_byte());
	endtask

	// Clean 8N1 frame on the receive line at the current bit period.
	task automatic send_frame(input logic [7:0] value, input int idle_len);
		logic [9:0] shape;
		shape = {1'b1, value, 1'b0};
		for (int b = 0; b < 10; b++)
			repeat (bit_ticks) line_tick(shape[b]);
		repeat (idle_len) line_tick(1'b1);
	endtask

	task automatic set_period(input logic [15:0] value);
		in_valid = 1'b0;
		while (pins_pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		bit_ticks = (value < 2) ? 1 : int'(value);
		settings_used++;
	endtask

	task automatic run_phase(input logic [15:0] value, input int budget, input bit hold);
		int first;
		int mode;
		set_period(value);
		gap_pct = hold ? 0 : 10 * $urandom_range(0, 3);
		stall_pct = 10 * $urandom_range(0, 3);
		req_pct = $urandom_range(5, 20);
		hold_armed = hold;
		first = ticks_sent;
		while (ticks_sent - first < budget) begin
			mode = $urandom_range(0, 9);
			if (mode < 8) begin
				send_frame(rand_byte(), $urandom_range(0, 2 * bit_ticks));
			end else if (mode == 8) begin
				repeat ($urandom_range(1, 20)) line_tick($urandom_range(0, 1));
			end else begin
				// lone low glitch: no filter, so it starts a bogus byte
				line_tick(1'b0);
				repeat ($urandom_range(1, 4)) line_tick(1'b1);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_data = uart_pkg::BIT_PERIOD_RST;
		bit_ticks = int'(uart_pkg::BIT_PERIOD_RST);
		gap_pct = 0;
		stall_pct = 0;
		req_pct = 0;
		hold_armed = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// levels straight out of reset
		send_tick(1'b1, 1'b0, 8'h00);
		send_tick(1'b1, 1'b0, 8'h00);

		// zero period: every bit and wait is one tick
		set_period(16'd0);
		send_tick(1'b1, 1'b1, 8'hFF);
		send_frame(8'h00, 0);
		send_tick(1'b1, 1'b1, 8'h00);
		req_pct = 100;
		send_frame(8'hFF, 2);

		// longest period, then shortened while both sides are mid-frame
		req_pct = 0;
		set_period(16'hFFFF);
		send_tick(1'b0, 1'b1, 8'hA5);
		repeat (30) line_tick(1'b1);
		set_period(16'd3);
		gap_pct = 20;
		stall_pct = 20;
		req_pct = 10;
		repeat (40) line_tick($urandom_range(0, 1));

		run_phase(16'd2, 50, 1'b1);
		run_phase(16'd0, 50, 1'b0);
		run_phase(16'd3, 50, 1'b0);
		run_phase(16'd1, 50, 1'b0);
		run_phase(16'd5, 50, 1'b0);
		run_phase(16'd2, 50, 1'b0);
		run_phase(16'd4, 50, 1'b0);

		in_valid = 1'b0;
		while (pins_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		$display("Checked %0d tick results across %0d bit period settings.",
			ticks_checked, settings_used);
		$display("Transmit frames started: %0d, bytes received: %0d.",
			frames_started, bytes_received);
		if (mismatches == 0 && pins_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
